### design/pgjc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgjc_pkg: shared types and constants for the PID gravity joint controller
// Register indexes, reset values, sine ROM generator, controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package pgjc_pkg;

	// default geometry
	localparam int ANGLE_WIDTH      = 24;
	localparam int ANGLE_FRAC_BITS  = 8;
	localparam int GAIN_FRAC_BITS   = 8;
	localparam int INTEGRAL_WIDTH   = 40;
	localparam int SINE_TABLE_DEPTH = 256;

	// divisor width of the serial dividers (covers 360 deg at 12 fraction bits)
	localparam int DIV_VW = 21;

	// configuration register indexes
	localparam logic [2:0] REG_KP        = 3'd0;
	localparam logic [2:0] REG_KI        = 3'd1;
	localparam logic [2:0] REG_KD        = 3'd2;
	localparam logic [2:0] REG_KG        = 3'd3;
	localparam logic [2:0] REG_OUT_LIMIT = 3'd4;
	localparam logic [2:0] REG_MIN_DRIVE = 3'd5;
	localparam logic [2:0] REG_DEADBAND  = 3'd6;
	localparam logic [2:0] REG_ADD_BASE  = 3'd7;

	// register reset values
	localparam logic [15:0] KP_RST        = 16'd1280;
	localparam logic [15:0] KI_RST        = 16'd0;
	localparam logic [15:0] KD_RST        = 16'd205;
	localparam logic [15:0] KG_RST        = 16'd17920;
	localparam logic [7:0]  OUT_LIMIT_RST = 8'd255;
	localparam logic [7:0]  MIN_DRIVE_RST = 8'd30;
	localparam logic [15:0] DEADBAND_RST  = 16'd128;

	// drive direction codes
	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_REV = 2'd2;

	// sine polynomial coefficients, Q30
	localparam logic [63:0] TC1 = 64'd1686629713;
	localparam logic [63:0] TC3 = 64'd693598668;
	localparam logic [63:0] TC5 = 64'd85569304;
	localparam logic [63:0] TC7 = 64'd5026995;
	localparam logic [63:0] TC9 = 64'd172272;

	// quarter-wave sine entry in Q15 from a Q30 phase x in [0, 1]
	function automatic logic [15:0] sine_val(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] v;
		x2 = (x * x) >> 30;
		p  = TC9;
		p  = TC7 - ((p * x2) >> 30);
		p  = TC5 - ((p * x2) >> 30);
		p  = TC3 - ((p * x2) >> 30);
		p  = TC1 - ((p * x2) >> 30);
		v  = (p * x) >> 30;
		v  = (v + 64'd16384) >> 15;
		return (v > 64'd32768) ? 16'd32768 : v[15:0];
	endfunction

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic calc;
		logic check;
		logic mul_ed;
		logic integ;
		logic mul_i;
		logic mul_d;
		logic dstart;
		logic acc_p;
		logic tlook;
		logic mul_g;
		logic acc_g;
		logic out_load;
	} pgjc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic db;
		logic busy;
	} pgjc_stat_t;

endpackage
`default_nettype wire

### design/pid_gravity_joint_control_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_gravity_joint_control_top: PID joint controller with gravity feedforward
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Each item (setpoint, position, base angle, elapsed ms) yields one drive
// command. An item outside the deadband is paced by the serial divider of the
// derivative term by the elapsed time, one quotient bit a cycle over a DIV_W
// bit dividend; DIV_W = max(INTEGRAL_WIDTH + 16, ANGLE_WIDTH + 28, ANGLE_WIDTH
// + log2(SINE_TABLE_DEPTH) + 3). The divisions by 1000 and by a full turn work
// eight bits a cycle and finish earlier. An item inside the deadband goes from
// the check straight to the result register. Items are worked one at a time; a
// finished result sits in the output register while the next item is taken.
// Configuration writes are always accepted and must arrive while the block
// is idle.
// ----------------------------------------------------------------------------
module pid_gravity_joint_control_top #(
	parameter int ANGLE_WIDTH      = pgjc_pkg::ANGLE_WIDTH,
	parameter int ANGLE_FRAC_BITS  = pgjc_pkg::ANGLE_FRAC_BITS,
	parameter int GAIN_FRAC_BITS   = pgjc_pkg::GAIN_FRAC_BITS,
	parameter int INTEGRAL_WIDTH   = pgjc_pkg::INTEGRAL_WIDTH,
	parameter int SINE_TABLE_DEPTH = pgjc_pkg::SINE_TABLE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [15:0]            cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [ANGLE_WIDTH-1:0] setpoint,
	input  wire logic [ANGLE_WIDTH-1:0] position,
	input  wire logic [ANGLE_WIDTH-1:0] base_angle,
	input  wire logic [15:0]            elapsed_ms,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [7:0]                  drive_level,
	output logic [1:0]                  drive_dir,
	output logic                        in_deadband
);
	import pgjc_pkg::*;

	localparam int DW_I  = INTEGRAL_WIDTH + 16;
	localparam int DW_D  = ANGLE_WIDTH + 28;
	localparam int DW_A  = ANGLE_WIDTH + $clog2(SINE_TABLE_DEPTH) + 3;
	localparam int DW_ID = (DW_I > DW_D) ? DW_I : DW_D;
	localparam int DIV_W = (DW_ID > DW_A) ? DW_ID : DW_A;

	pgjc_cmd_t  cmd;
	pgjc_stat_t stat;

	assign cfg_ready = 1'b1;

	pgjc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pgjc_dp #(
		.ANGLE_WIDTH      (ANGLE_WIDTH),
		.ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
		.GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
		.INTEGRAL_WIDTH   (INTEGRAL_WIDTH),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.DIV_W            (DIV_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.setpoint    (setpoint),
		.position    (position),
		.base_angle  (base_angle),
		.elapsed_ms  (elapsed_ms),
		.drive_level (drive_level),
		.drive_dir   (drive_dir),
		.in_deadband (in_deadband)
	);

endmodule
`default_nettype wire

### design/pgjc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgjc_div: dividers for the joint controller datapath
// pgjc_div is a restoring long divider, one quotient bit per cycle.
// pgjc_cdiv divides by a constant, RW quotient bits per cycle, each digit
// taken from a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module pgjc_div #(
	parameter int DW = 56,
	parameter int VW = 21
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               busy,
	output logic [DW-1:0]      quot,
	output logic [VW-1:0]      rem
);
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quot_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          take;

	// trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q, quot_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
		take  = (trial >= {1'b0, dvs_q});
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (cnt_q != '0) begin
			quot_q <= {quot_q[DW-2:0], take};
			rem_q  <= take ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// constant divisor, ceil(DW / RW) quotient digits of RW bits; DIVISOR must be below 2^VW
module pgjc_cdiv #(
	parameter int DW      = 56,
	parameter int VW      = 21,
	parameter int DIVISOR = 1000,
	parameter int RW      = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	output logic               busy,
	output logic [DW-1:0]      quot,
	output logic [VW-1:0]      rem
);
	localparam int ND = (DW + RW - 1) / RW;
	localparam int XW = ND * RW;
	localparam int TW = VW + RW;
	localparam int CW = $clog2(ND + 1);
	localparam logic [TW-1:0] RECIP = TW'((64'd1 << TW) / 64'(DIVISOR));
	localparam logic [TW-1:0] DVS   = TW'(DIVISOR);

	logic [CW-1:0]   cnt_q;
	logic [XW-1:0]   num_q;
	logic [XW-1:0]   quot_q;
	logic [VW-1:0]   rem_q;
	logic [TW-1:0]   t;
	logic [2*TW-1:0] est;
	logic [RW-1:0]   qd;
	logic [TW-1:0]   r_est;
	logic            fix;

	// next digit: the reciprocal estimate is exact or one low
	always_comb begin
		t     = {rem_q, num_q[XW-1 -: RW]};
		est   = (2*TW)'(t) * (2*TW)'(RECIP);
		qd    = est[TW +: RW];
		r_est = t - TW'(qd) * DVS;
		fix   = (r_est >= DVS);
	end

	// digit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(ND);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// one quotient digit per cycle, most significant first
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= XW'(dividend);
			quot_q <= '0;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			num_q  <= num_q << RW;
			quot_q <= {quot_q[XW-RW-1:0], qd + RW'(fix)};
			rem_q  <= fix ? VW'(r_est - DVS) : VW'(r_est);
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = quot_q[DW-1:0];
	assign rem  = rem_q;

endmodule
`default_nettype wire

### design/pgjc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgjc_dp: PID gravity controller datapath
// Register file, control state, shared multiplier, a serial divider by the
// elapsed time, two constant dividers, sine ROM, accumulator and drive shaping.
// ----------------------------------------------------------------------------
module pgjc_dp #(
	parameter int ANGLE_WIDTH      = pgjc_pkg::ANGLE_WIDTH,
	parameter int ANGLE_FRAC_BITS  = pgjc_pkg::ANGLE_FRAC_BITS,
	parameter int GAIN_FRAC_BITS   = pgjc_pkg::GAIN_FRAC_BITS,
	parameter int INTEGRAL_WIDTH   = pgjc_pkg::INTEGRAL_WIDTH,
	parameter int SINE_TABLE_DEPTH = pgjc_pkg::SINE_TABLE_DEPTH,
	parameter int DIV_W            = 56
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pgjc_pkg::pgjc_cmd_t    cmd,
	output pgjc_pkg::pgjc_stat_t        stat,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [15:0]            cfg_data,
	input  wire logic [ANGLE_WIDTH-1:0] setpoint,
	input  wire logic [ANGLE_WIDTH-1:0] position,
	input  wire logic [ANGLE_WIDTH-1:0] base_angle,
	input  wire logic [15:0]            elapsed_ms,
	output logic [7:0]                  drive_level,
	output logic [1:0]                  drive_dir,
	output logic                        in_deadband
);
	import pgjc_pkg::*;

	localparam int AW    = ANGLE_WIDTH;
	localparam int IW    = INTEGRAL_WIDTH;
	localparam int BW    = (IW > AW + 2) ? IW : AW + 2;
	localparam int PRW   = 16 + BW;
	localparam int NW    = ((IW > AW + 18) ? IW : AW + 18) + 1;
	localparam int SUM_W = DIV_W + 3;
	localparam int SH    = GAIN_FRAC_BITS + ANGLE_FRAC_BITS;
	localparam int KW    = $clog2(SINE_TABLE_DEPTH);
	localparam int PW    = KW + 2;
	localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
	localparam int MS_PER_S  = 1000;

	// configuration registers
	logic [15:0] kp_q, ki_q, kd_q, kg_q, deadband_q;
	logic [7:0]  out_limit_q, min_drive_q;
	logic        add_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= KP_RST;
			ki_q        <= KI_RST;
			kd_q        <= KD_RST;
			kg_q        <= KG_RST;
			out_limit_q <= OUT_LIMIT_RST;
			min_drive_q <= MIN_DRIVE_RST;
			deadband_q  <= DEADBAND_RST;
			add_base_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:        kp_q        <= cfg_data;
				REG_KI:        ki_q        <= cfg_data;
				REG_KD:        kd_q        <= cfg_data;
				REG_KG:        kg_q        <= cfg_data;
				REG_OUT_LIMIT: out_limit_q <= cfg_data[7:0];
				REG_MIN_DRIVE: min_drive_q <= cfg_data[7:0];
				REG_DEADBAND:  deadband_q  <= cfg_data;
				REG_ADD_BASE:  add_base_q  <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// input item latch
	logic signed [AW-1:0] sp_q, pos_q, base_q;
	logic [15:0]          dt_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sp_q   <= setpoint;
			pos_q  <= position;
			base_q <= base_angle;
			dt_q   <= (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;
		end
	end

	// error and gravity angle
	logic signed [AW:0] err_q, angle_q;
	logic [AW:0]        aerr, aangle;
	logic               db;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			err_q   <= (AW+1)'(sp_q) - (AW+1)'(pos_q);
			angle_q <= (AW+1)'(pos_q) + (add_base_q ? (AW+1)'(base_q) : '0);
		end
	end

	always_comb begin
		aerr   = err_q[AW] ? -err_q : err_q;
		aangle = angle_q[AW] ? -angle_q : angle_q;
		db     = (aerr < (AW+1)'(deadband_q));
	end

	// controller state: integral and last error
	logic signed [IW-1:0] integral_q;
	logic signed [AW:0]   last_q;
	logic signed [AW+1:0] diff_q;
	logic                 db_q;
	logic [PRW-1:0]       prod_q;
	logic signed [NW-1:0] isum;
	logic signed [NW-1:0] inc;
	logic signed [IW-1:0] isat;

	// integral update with saturation
	always_comb begin
		inc  = err_q[AW] ? -NW'(prod_q) : NW'(prod_q);
		isum = NW'(integral_q) + inc;
		if (isum[NW-1:IW-1] == '0 || isum[NW-1:IW-1] == '1) begin
			isat = isum[IW-1:0];
		end else if (isum[NW-1]) begin
			isat = {1'b1, {(IW-1){1'b0}}};
		end else begin
			isat = {1'b0, {(IW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			last_q     <= '0;
		end else if (cmd.check && db) begin
			integral_q <= '0;
			last_q     <= err_q;
		end else if (cmd.integ) begin
			integral_q <= isat;
			last_q     <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			db_q <= db;
		end
		if (cmd.integ) begin
			diff_q <= (AW+2)'(err_q) - (AW+2)'(last_q);
		end
	end

	// shared multiplier
	logic [15:0]    mul_a;
	logic [BW-1:0]  mul_b;
	logic [PRW-1:0] mul_out;
	logic [IW-1:0]  aint;
	logic [AW+1:0]  adiff;
	logic [15:0]    t_q;

	always_comb begin
		aint  = integral_q[IW-1] ? -integral_q : integral_q;
		adiff = diff_q[AW+1] ? -diff_q : diff_q;
		mul_a = dt_q;
		mul_b = BW'(aerr);
		if (cmd.mul_i) begin
			mul_a = ki_q;
			mul_b = BW'(aint);
		end else if (cmd.mul_d) begin
			mul_a = kd_q;
			mul_b = BW'(adiff);
		end else if (cmd.dstart) begin
			mul_a = kp_q;
			mul_b = BW'(aerr);
		end else if (cmd.mul_g) begin
			mul_a = kg_q;
			mul_b = BW'(t_q);
		end
		mul_out = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_ed || cmd.mul_i || cmd.mul_d || cmd.dstart || cmd.mul_g) begin
			prod_q <= mul_out;
		end
	end

	// dividers: integral/1000, derivative*1000/dt, angle phase
	logic [PRW+9:0]    p1000;
	logic              busy_i, busy_d, busy_a;
	logic [DIV_W-1:0]  quot_i, quot_d, quot_a;
	logic [DIV_VW-1:0] rem_i, rem_d, rem_a;
	logic              isgn_q, dsgn_q;

	assign p1000 = {prod_q, 10'd0} - {6'd0, prod_q, 4'd0} - {7'd0, prod_q, 3'd0};

	always_ff @(posedge clk) begin
		if (cmd.mul_i) begin
			isgn_q <= integral_q[IW-1];
		end
		if (cmd.mul_d) begin
			dsgn_q <= diff_q[AW+1];
		end
	end

	pgjc_cdiv #(.DW(DIV_W), .VW(DIV_VW), .DIVISOR(MS_PER_S)) u_div_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mul_d),
		.dividend (DIV_W'(prod_q)),
		.busy     (busy_i),
		.quot     (quot_i),
		.rem      (rem_i)
	);

	pgjc_div #(.DW(DIV_W), .VW(DIV_VW)) u_div_d (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.dstart),
		.dividend (DIV_W'(p1000)),
		.divisor  (DIV_VW'(dt_q)),
		.busy     (busy_d),
		.quot     (quot_d),
		.rem      (rem_d)
	);

	pgjc_cdiv #(.DW(DIV_W), .VW(DIV_VW), .DIVISOR(FULL_TURN)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.check && !db),
		.dividend (DIV_W'({aangle, {PW{1'b0}}})),
		.busy     (busy_a),
		.quot     (quot_a),
		.rem      (rem_a)
	);

	assign stat.db   = db;
	assign stat.busy = busy_i | busy_d | busy_a;

	// sine quarter-wave ROM
	logic [15:0] sin_tab [SINE_TABLE_DEPTH+1];

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
		localparam logic [63:0] XV = (64'(g) << 30) / SINE_TABLE_DEPTH;
		assign sin_tab[g] = sine_val(XV);
	end

	// phase, quadrant and table index (floor for negative angles)
	logic [PW-1:0] qlo, qadj, phase;
	logic [KW:0]   tidx;
	logic          gneg_q;

	always_comb begin
		qlo   = quot_a[PW-1:0];
		qadj  = qlo + PW'(rem_a != '0);
		phase = angle_q[AW] ? -qadj : qlo;
		tidx  = phase[PW-2] ? ((KW+1)'(SINE_TABLE_DEPTH) - (KW+1)'(phase[KW-1:0]))
		                    : (KW+1)'(phase[KW-1:0]);
	end

	// term accumulator
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] pterm, iterm, dterm, gterm;

	always_comb begin
		pterm = SUM_W'(prod_q);
		iterm = isgn_q ? -SUM_W'(quot_i) : SUM_W'(quot_i);
		dterm = dsgn_q ? -SUM_W'(quot_d) : SUM_W'(quot_d);
		gterm = (SUM_W'(prod_q) << ANGLE_FRAC_BITS) >> 15;
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_p) begin
			acc_q <= err_q[AW] ? -pterm : pterm;
		end else if (cmd.tlook) begin
			acc_q <= acc_q + iterm + dterm;
		end else if (cmd.acc_g) begin
			acc_q <= gneg_q ? acc_q - gterm : acc_q + gterm;
		end
		if (cmd.tlook) begin
			t_q    <= sin_tab[tidx];
			gneg_q <= phase[PW-1];
		end
	end

	// drive shaping
	logic             neg;
	logic [SUM_W-1:0] mag, lim, magc, lvl_full;
	logic [7:0]       level;
	logic [1:0]       dir;

	always_comb begin
		neg      = acc_q[SUM_W-1];
		mag      = neg ? -acc_q : acc_q;
		lim      = SUM_W'(out_limit_q) << SH;
		magc     = (mag > lim) ? lim : mag;
		lvl_full = magc >> SH;
		level    = 8'd0;
		dir      = DIR_OFF;
		if (magc > (SUM_W'(1) << (SH - 1))) begin
			level = lvl_full[7:0];
			if (magc < (SUM_W'(min_drive_q) << SH)) begin
				level = min_drive_q;
			end
			dir = neg ? DIR_REV : DIR_FWD;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			drive_level <= db_q ? 8'd0 : level;
			drive_dir   <= db_q ? DIR_OFF : dir;
			in_deadband <= db_q;
		end
	end

endmodule
`default_nettype wire

### design/pgjc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgjc_ctrl: PID gravity controller sequencer
// Steps one item through the datapath and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pgjc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire pgjc_pkg::pgjc_stat_t stat,
	output pgjc_pkg::pgjc_cmd_t       cmd
);
	import pgjc_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_CALC   = 14'b00000000000010,
		ST_CHECK  = 14'b00000000000100,
		ST_MUL_ED = 14'b00000000001000,
		ST_INTEG  = 14'b00000000010000,
		ST_MUL_I  = 14'b00000000100000,
		ST_MUL_D  = 14'b00000001000000,
		ST_DSTART = 14'b00000010000000,
		ST_ACC_P  = 14'b00000100000000,
		ST_WAIT   = 14'b00001000000000,
		ST_TLOOK  = 14'b00010000000000,
		ST_MUL_G  = 14'b00100000000000,
		ST_ACC_G  = 14'b01000000000000,
		ST_FINISH = 14'b10000000000000
	} pgjc_state_t;

	pgjc_state_t state_q, state_d;
	logic        out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.db ? ST_FINISH : ST_MUL_ED;
			end
			ST_MUL_ED: begin
				cmd.mul_ed = 1'b1;
				state_d    = ST_INTEG;
			end
			ST_INTEG: begin
				cmd.integ = 1'b1;
				state_d   = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.mul_i = 1'b1;
				state_d   = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.mul_d = 1'b1;
				state_d   = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.dstart = 1'b1;
				state_d    = ST_ACC_P;
			end
			ST_ACC_P: begin
				cmd.acc_p = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (!stat.busy) begin
					state_d = ST_TLOOK;
				end
			end
			ST_TLOOK: begin
				cmd.tlook = 1'b1;
				state_d   = ST_MUL_G;
			end
			ST_MUL_G: begin
				cmd.mul_g = 1'b1;
				state_d   = ST_ACC_G;
			end
			ST_ACC_G: begin
				cmd.acc_g = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				// wait for the result register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
